### rtl/ldfs_pkg.sv
package ldfs_pkg;

  // input item kinds
  typedef enum logic [1:0] {
    MODE_STORE = 2'd0,
    MODE_GRAY  = 2'd1,
    MODE_FUNC  = 2'd2,
    MODE_NONE  = 2'd3
  } ldfs_mode_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 1'd1;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned WORD_W  = 8;

  localparam logic [WORD_W-1:0] CMD_GRAY = 8'h00;
  localparam logic [WORD_W-1:0] CMD_FUNC = 8'h01;

  // function frame table
  localparam int unsigned FUN_WORDS = 34;
  localparam int unsigned FUN_WIDE  = 18;
  localparam int unsigned FUN_IDX_W = 6;
  localparam int unsigned FUN_BLANK_BYTE  = 16;
  localparam int unsigned FUN_BRIGHT_BYTE = 17;

  localparam logic [WORD_W-1:0] FUN_TABLE [FUN_WORDS] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h01, 8'h87, 8'h10,
    8'h7F,
    8'h60, 8'h27, 8'h7F, 8'h60, 8'h27, 8'h7F, 8'h60, 8'h27, 8'h7F,
    8'h60, 8'h27, 8'h7F, 8'h60, 8'h27, 8'h7F
  };

  // configuration registers as seen by the sequencer
  typedef struct packed {
    logic       blank;
    logic [6:0] brightness;
  } ldfs_cfg_t;

  // write request into the level store
  typedef struct packed {
    logic               en;
    logic [CHAN_W-1:0]  chan;
    logic [LEVEL_W-1:0] level;
  } ldfs_wr_t;

  // table word with blank and brightness patched in
  function automatic logic [WORD_W-1:0] fun_word(logic [FUN_IDX_W-1:0] idx,
                                                 ldfs_cfg_t cfg);
    logic [WORD_W-1:0] w;
    w = FUN_TABLE[idx];
    if (idx == FUN_IDX_W'(FUN_BLANK_BYTE)) begin
      w[1] = ~cfg.blank;
    end else if (idx == FUN_IDX_W'(FUN_BRIGHT_BYTE)) begin
      w = {cfg.blank, cfg.brightness};
    end
    return w;
  endfunction

endpackage

### rtl/ldfs_gray_mem.sv
module ldfs_gray_mem
  import ldfs_pkg::*;
#(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned ADDR_W   = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ldfs_wr_t           wr_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output logic [LEVEL_W-1:0] rdata_o
);

  logic [LEVEL_W-1:0]  mem [CHANNELS];
  logic [CHANNELS-1:0] valid_q;
  logic [LEVEL_W-1:0]  rdata_q;
  logic                wr_hit;

  // only channels inside the store are written
  assign wr_hit = wr_i.en && ({1'b0, wr_i.chan} < (CHAN_W + 1)'(CHANNELS));

  // valid bits, cleared at reset so unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_hit) begin
      valid_q[wr_i.chan[ADDR_W-1:0]] <= 1'b1;
    end
  end

  // storage write port
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem[wr_i.chan[ADDR_W-1:0]] <= wr_i.level;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : '0;
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ldfs_frame_seq.sv
module ldfs_frame_seq
  import ldfs_pkg::*;
#(
  parameter int unsigned CHANNELS = 16,
  parameter int unsigned ADDR_W   = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ldfs_cfg_t          cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_mode_i,
  input  logic [CHAN_W-1:0]  in_chan_i,
  input  logic [LEVEL_W-1:0] in_level_i,
  output ldfs_wr_t           wr_o,
  output logic [ADDR_W-1:0]  raddr_o,
  input  logic [LEVEL_W-1:0] rdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [WORD_W-1:0]  out_word_o,
  output logic               out_seven_o,
  output logic               out_last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCMD,
    S_GHI,
    S_GLO,
    S_FUN
  } state_e;

  localparam logic [ADDR_W-1:0] LAST_CH = ADDR_W'(CHANNELS - 1);

  state_e                state_q;
  logic [ADDR_W-1:0]     ch_q, ch_d;
  logic [FUN_IDX_W:0]    fidx_q;
  logic [FUN_IDX_W-1:0]  tidx;
  logic                  out_valid_q;
  logic [WORD_W-1:0]     out_word_q;
  logic                  out_seven_q;
  logic                  out_last_q;
  logic                  adv;
  logic                  in_fire;
  ldfs_mode_e            mode;

  assign mode    = ldfs_mode_e'(in_mode_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign adv     = !out_valid_q || out_ready_i;
  assign tidx    = FUN_IDX_W'(fidx_q - 1'b1);

  // store requests go straight to the memory write port
  assign wr_o.en    = in_fire && (mode == MODE_STORE);
  assign wr_o.chan  = in_chan_i;
  assign wr_o.level = in_level_i;

  // read address runs one channel ahead so data is ready for the high byte
  always_comb begin
    ch_d = ch_q;
    if (state_q == S_IDLE) begin
      ch_d = '0;
    end else if (state_q == S_GLO && adv && ch_q != LAST_CH) begin
      ch_d = ch_q + 1'b1;
    end
  end

  assign raddr_o = ch_d;

  // frame state machine and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      fidx_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_seven_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      ch_q <= ch_d;
      unique case (state_q)
        S_IDLE: begin
          fidx_q <= '0;
          // final word of a frame drains from the output register
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_fire) begin
            unique case (mode)
              MODE_GRAY: state_q <= S_GCMD;
              MODE_FUNC: state_q <= S_FUN;
              default:   state_q <= S_IDLE;
            endcase
          end
        end
        S_GCMD: begin
          if (adv) begin
            out_valid_q <= 1'b1;
            out_word_q  <= CMD_GRAY;
            out_seven_q <= 1'b0;
            out_last_q  <= 1'b0;
            state_q     <= S_GHI;
          end
        end
        S_GHI: begin
          if (adv) begin
            out_valid_q <= 1'b1;
            out_word_q  <= rdata_i[15:8];
            out_seven_q <= 1'b0;
            out_last_q  <= 1'b0;
            state_q     <= S_GLO;
          end
        end
        S_GLO: begin
          if (adv) begin
            out_valid_q <= 1'b1;
            out_word_q  <= rdata_i[7:0];
            out_seven_q <= 1'b0;
            out_last_q  <= (ch_q == LAST_CH);
            state_q     <= (ch_q == LAST_CH) ? S_IDLE : S_GHI;
          end
        end
        S_FUN: begin
          if (adv) begin
            out_valid_q <= 1'b1;
            fidx_q      <= fidx_q + 1'b1;
            if (fidx_q == '0) begin
              out_word_q  <= CMD_FUNC;
              out_seven_q <= 1'b0;
              out_last_q  <= 1'b0;
            end else begin
              out_word_q  <= fun_word(tidx, cfg_i);
              out_seven_q <= (tidx >= FUN_IDX_W'(FUN_WIDE));
              out_last_q  <= (tidx == FUN_IDX_W'(FUN_WORDS - 1));
              if (tidx == FUN_IDX_W'(FUN_WORDS - 1)) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_seven_o = out_seven_q;
  assign out_last_o  = out_last_q;

endmodule

### rtl/led_driver_frame_serializer.sv
// first word: the sequencer leaves idle, then registers the frame's command word
// throughput: grayscale frame 1 + 2*CHANNELS words, function frame 35 words, one
//   per cycle from the output register unless stalled; level read is one channel ahead
// a store request leaves the input ready; a frame request holds it to its last word
// reset: async active low, level store valid bits clear at once (all levels zero),
//   blank = 1, brightness = 16
module led_driver_frame_serializer
  import ldfs_pkg::*;
#(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // channel[3:0], level[19:4], zero pad
  input  logic [1:0]           s_axis_tuser,  // mode[1:0]
  // word stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // tx_byte[7:0]
  output logic                 m_axis_tuser,  // seven_bit
  output logic                 m_axis_tlast   // last_and_latch
);

  localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ldfs_cfg_t          cfg_q;
  ldfs_wr_t           wr;
  logic [ADDR_W-1:0]  raddr;
  logic [LEVEL_W-1:0] rdata;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blank      <= 1'b1;
      cfg_q.brightness <= 7'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BLANK:  cfg_q.blank      <= cfg_data_i[0];
        REG_BRIGHT: cfg_q.brightness <= cfg_data_i[6:0];
        default:    cfg_q            <= cfg_q;
      endcase
    end
  end

  // level store
  ldfs_gray_mem #(
    .CHANNELS (CHANNELS),
    .ADDR_W   (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // frame sequencer
  ldfs_frame_seq #(
    .CHANNELS (CHANNELS),
    .ADDR_W   (ADDR_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_chan_i   (s_axis_tdata[3:0]),
    .in_level_i  (s_axis_tdata[19:4]),
    .wr_o        (wr),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (m_axis_tdata),
    .out_seven_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### tb/led_driver_frame_serializer_tb.sv
`timescale 1ns / 100ps

module led_driver_frame_serializer_tb;
  import ldfs_pkg::*;

  localparam int unsigned CHANNELS      = 16;
  localparam int unsigned FRAME_FUNC_N  = 34;
  localparam int unsigned FRAME_WIDE_N  = 18;
  localparam int unsigned BLANK_BYTE    = 16;
  localparam int unsigned BRIGHT_BYTE   = 17;
  localparam logic [7:0]  GRAY_CMD_WORD = 8'h00;
  localparam logic [7:0]  FUNC_CMD_WORD = 8'h01;
  localparam int unsigned IDLE_HOLD     = 8;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned MAX_REPORTS   = 10;

  // fixed function frame contents before blank and brightness patching
  localparam logic [7:0] FUNC_FRAME_WORDS [FRAME_FUNC_N] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h01, 8'h87, 8'h10,
    8'h7F,
    8'h60, 8'h27, 8'h7F, 8'h60, 8'h27, 8'h7F, 8'h60, 8'h27, 8'h7F,
    8'h60, 8'h27, 8'h7F, 8'h60, 8'h27, 8'h7F
  };

  typedef struct packed {
    ldfs_mode_e         mode;
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
  } led_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              seven_bit;
    logic              latch;
  } led_word_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [7:0]           cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata  = '0;  // channel[3:0], level[19:4], zero pad
  logic [1:0]           s_axis_tuser  = '0;  // mode[1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;        // tx_byte[7:0]
  logic                 m_axis_tuser;        // seven_bit
  logic                 m_axis_tlast;        // last_and_latch

  // predictor state
  logic [LEVEL_W-1:0] gray_store [CHANNELS] = '{default: '0};
  logic               cfg_blank  = 1'b1;
  logic [6:0]         cfg_bright = 7'd16;

  led_req_t  req_q [$];
  led_req_t  cur_req;
  led_word_t frame_words_q [$];
  int        pending_reqs   = 0;
  int        errors         = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        quiet_cycles   = 0;

  led_driver_frame_serializer #(
    .CHANNELS(CHANNELS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // update the level store or queue the words a frame request should produce
  function automatic void predict_frame(led_req_t req);
    logic [7:0] w;
    case (req.mode)
      MODE_STORE: begin
        if (req.channel < CHANNELS) gray_store[req.channel] = req.level;
      end
      MODE_GRAY: begin
        frame_words_q.push_back('{GRAY_CMD_WORD, 1'b0, 1'b0});
        for (int ch = 0; ch < CHANNELS; ch++) begin
          frame_words_q.push_back('{gray_store[ch][15:8], 1'b0, 1'b0});
          frame_words_q.push_back('{gray_store[ch][7:0], 1'b0, ch == CHANNELS - 1});
        end
      end
      MODE_FUNC: begin
        frame_words_q.push_back('{FUNC_CMD_WORD, 1'b0, 1'b0});
        for (int k = 0; k < FRAME_FUNC_N; k++) begin
          w = FUNC_FRAME_WORDS[k];
          if (k == BLANK_BYTE) w[1] = !cfg_blank;
          if (k == BRIGHT_BYTE) w = {cfg_blank, cfg_bright};
          frame_words_q.push_back('{w, k >= FRAME_WIDE_N, k == FRAME_FUNC_N - 1});
        end
      end
      default: ;
    endcase
  endfunction

  // compare one received word against the oldest expected word
  function automatic void check_word(led_word_t got);
    led_word_t want;
    if (frame_words_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: unexpected word data=%h seven_bit=%b last=%b",
                 $time, got.data, got.seven_bit, got.latch);
      return;
    end
    want = frame_words_q.pop_front();
    if (got.data !== want.data || got.seven_bit !== want.seven_bit ||
        got.latch !== want.latch) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display({"%0t: word mismatch data exp %h got %h, ",
                  "seven_bit exp %b got %b, last exp %b got %b"},
                 $time, want.data, got.data, want.seven_bit, got.seven_bit,
                 want.latch, got.latch);
    end
  endfunction

  // random request, mostly stores and frames, occasionally the unused mode
  function automatic led_req_t rand_req();
    led_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      r.mode = MODE_STORE;
    else if (pick < 75) r.mode = MODE_GRAY;
    else if (pick < 95) r.mode = MODE_FUNC;
    else                r.mode = MODE_NONE;
    r.channel = CHAN_W'($urandom);
    pick = $urandom_range(0, 7);
    if (pick == 0)      r.level = '1;
    else if (pick == 1) r.level = '0;
    else                r.level = LEVEL_W'($urandom);
    return r;
  endfunction

  task automatic queue_req(ldfs_mode_e mode, logic [CHAN_W-1:0] ch, logic [LEVEL_W-1:0] lvl);
    req_q.push_back('{mode, ch, lvl});
    pending_reqs++;
  endtask

  task automatic queue_random(int n);
    for (int k = 0; k < n; k++) begin
      req_q.push_back(rand_req());
      pending_reqs++;
    end
  endtask

  // wait for all requests and frames to finish, then let the block settle
  task automatic wait_idle();
    while (pending_reqs != 0 || frame_words_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_HOLD) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_BLANK) cfg_blank = value[0];
    else                  cfg_bright = value[6:0];
    cfg_valid_i <= 1'b0;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predict_frame(cur_req);
        pending_reqs--;
      end
      if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_req = req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, cur_req.level, cur_req.channel};
        s_axis_tuser  <= cur_req.mode;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // word monitor with random backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_word('{m_axis_tdata, m_axis_tuser, m_axis_tlast});
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL led_driver_frame_serializer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // frames straight out of reset
    queue_req(MODE_GRAY, 4'd0, 16'h0000);
    queue_req(MODE_FUNC, 4'd0, 16'h0000);
    wait_idle();
    // blank off, brightness zero, upper data bits ignored
    write_cfg(REG_BLANK, 8'hFE);
    write_cfg(REG_BRIGHT, 8'h80);
    queue_req(MODE_FUNC, 4'd9, 16'hFFFF);
    wait_idle();
    // blank on, full brightness
    write_cfg(REG_BLANK, 8'h01);
    write_cfg(REG_BRIGHT, 8'hFF);
    queue_req(MODE_FUNC, 4'd0, 16'h0000);
    // level extremes, first and last channel, unused mode ignored
    queue_req(MODE_STORE, 4'd0, 16'hFFFF);
    queue_req(MODE_STORE, 4'd15, 16'h8001);
    queue_req(MODE_STORE, 4'd7, 16'h00FF);
    queue_req(MODE_STORE, 4'd8, 16'hFF00);
    queue_req(MODE_NONE, 4'd5, 16'hFFFF);
    queue_req(MODE_NONE, 4'd0, 16'h1234);
    queue_req(MODE_GRAY, 4'd0, 16'h0000);
    // overwrites and back-to-back stores
    queue_req(MODE_STORE, 4'd0, 16'h0000);
    queue_req(MODE_STORE, 4'd1, 16'hAAAA);
    queue_req(MODE_STORE, 4'd14, 16'h5555);
    queue_req(MODE_GRAY, 4'd3, 16'hFFFF);
    queue_req(MODE_FUNC, 4'd15, 16'hFFFF);
    queue_req(MODE_STORE, 4'd15, 16'hFFFF);
    queue_req(MODE_STORE, 4'd15, 16'h0001);
    queue_req(MODE_GRAY, 4'd15, 16'h7FFE);
    wait_idle();

    // random phases with different idling and register settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          write_cfg(REG_BLANK, 8'h00);
          write_cfg(REG_BRIGHT, 8'h7F);
        end
        1: begin
          send_idle_pct = 52; recv_stall_pct = 0;
          write_cfg(REG_BLANK, 8'h01);
          write_cfg(REG_BRIGHT, 8'h00);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 52;
          write_cfg(REG_BLANK, 8'($urandom));
          write_cfg(REG_BRIGHT, 8'($urandom));
        end
        default: begin
          send_idle_pct = 19; recv_stall_pct = 19;
          write_cfg(REG_BRIGHT, 8'($urandom));
          write_cfg(REG_BLANK, 8'($urandom));
        end
      endcase
      queue_random(31);
      // sender holds off until every pending word has come out
      wait_idle();
      queue_random(31);
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    if (errors == 0 && frame_words_q.size() == 0) begin
      $display("PASS led_driver_frame_serializer");
    end else begin
      $display("FAIL led_driver_frame_serializer");
    end
    $finish;
  end

endmodule

### files.f
rtl/ldfs_pkg.sv
rtl/ldfs_gray_mem.sv
rtl/ldfs_frame_seq.sv
rtl/led_driver_frame_serializer.sv
tb/led_driver_frame_serializer_tb.sv
